>>> sv/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
// Used by the controller, the datapath and the top level; depends on nothing.
package bdq_pkg;

    // Command codes carried in the command field of an input beat.
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_COUNT      = 3'd4,
        CMD_SEARCH     = 3'd5,
        CMD_LIST       = 3'd6
    } op_t;

    // Status codes carried in a result beat.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } st_t;

    // One input beat.
    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         position;
        logic signed [31:0] element;
        logic               last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the accepted input beat
        logic push;        // store the value and emit an ok result
        logic pop_issue;   // read the popped entry and update the pointers
        logic pop_emit;    // emit the popped value
        logic emit_status; // emit a bare status result
        st_t  status;      // status used by emit_status
        logic emit_count;  // emit the occupancy
        logic walk_start;  // reset the walk counters
        logic walk_adv;    // advance the walk by one entry
        logic walk_final;  // emit the closing search result
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;        // latched command code
        logic       full;
        logic       empty;
        logic       out_free;  // the result register can take a beat now
        logic       walk_busy; // entries still in flight or left to read
        logic       b_emit;    // the entry at hand would produce a beat
    } dp_stat_t;

endpackage

>>> sv/bdq_ctrl.sv
// Controller state machine for the bounded deque with search.
// Depends on bdq_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_POP   = 4'b0100,
        S_WALK  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Input beats are taken only between commands.
    assign item_stall = (state_reg != S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (stat.op)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK:
                    begin
                        if (stat.out_free)
                        begin
                            if (stat.full)
                            begin
                                cmd.emit_status = 1'b1;
                                cmd.status      = ST_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit_status = 1'b1;
                                cmd.status      = ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.pop_issue = 1'b1;
                            state_next    = S_POP;
                        end
                    end
                    CMD_COUNT:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit_count = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    CMD_SEARCH, CMD_LIST:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit_status = 1'b1;
                                cmd.status      = ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    default:
                    begin
                        // An unused command code produces nothing.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.pop_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (stat.walk_busy)
                begin
                    if (!stat.b_emit || stat.out_free)
                    begin
                        cmd.walk_adv = 1'b1;
                    end
                end
                else if (stat.op == CMD_LIST)
                begin
                    // The last listed entry already carried the last flag.
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.walk_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/bdq_datapath.sv
// Datapath for the bounded deque with search: ring store, pointers, walk
// pipeline and result register. Depends on bdq_pkg; driven by bdq_ctrl.
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    item,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Ring slot at a given offset from a base slot.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offs);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(offs);
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;

    logic [2:0]    op_reg;
    logic [31:0]   key_reg;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          b_valid_reg, b_valid_next;
    logic [CW-1:0] b_idx_reg, b_idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [4:0]    pend_pos_reg, pend_pos_next;
    logic          out_valid_reg;
    result_t       out_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          emit;
    result_t       res_new;

    logic [AW-1:0] front_inc;
    logic [AW-1:0] front_dec;
    logic          walk_more;
    logic          b_match;
    logic          b_last;

    // Pointer arithmetic and walk conditions.
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign walk_more = (rd_idx_reg < occ_reg);
    assign b_match   = (rd_data_reg == key_reg);
    assign b_last    = ((b_idx_reg + CW'(1)) == occ_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = (occ_reg == CW'(DEPTH));
        stat.empty     = (occ_reg == '0);
        stat.out_free  = !out_valid_reg || !result_stall;
        stat.walk_busy = b_valid_reg || walk_more;
        stat.b_emit    = b_valid_reg &&
                         ((op_reg == CMD_LIST) || (b_match && pend_valid_reg));
    end

    // Next values of the pointers, the walk and the new result beat.
    always_comb
    begin
        front_next      = front_reg;
        occ_next        = occ_reg;
        rd_idx_next     = rd_idx_reg;
        b_valid_next    = b_valid_reg;
        b_idx_next      = b_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        mem_we          = 1'b0;
        mem_waddr       = front_reg;
        mem_re          = 1'b0;
        mem_raddr       = front_reg;
        emit            = 1'b0;
        res_new         = '0;
        res_new.status  = ST_OK;
        res_new.last    = 1'b1;

        if (cmd.push)
        begin
            mem_we = 1'b1;
            if (op_reg == CMD_PUSH_FRONT)
            begin
                front_next = front_dec;
                mem_waddr  = front_dec;
            end
            else
            begin
                mem_waddr = slot_of(front_reg, occ_reg);
            end
            occ_next = occ_reg + 1'b1;
            emit     = 1'b1;
        end

        if (cmd.emit_status)
        begin
            emit           = 1'b1;
            res_new.status = cmd.status;
        end

        if (cmd.emit_count)
        begin
            emit             = 1'b1;
            res_new.position = 5'(occ_reg);
        end

        if (cmd.pop_issue)
        begin
            mem_re = 1'b1;
            if (op_reg == CMD_POP_FRONT)
            begin
                mem_raddr  = front_reg;
                front_next = front_inc;
            end
            else
            begin
                mem_raddr = slot_of(front_reg, occ_reg - 1'b1);
            end
            occ_next = occ_reg - 1'b1;
        end

        if (cmd.pop_emit)
        begin
            emit            = 1'b1;
            res_new.element = rd_data_reg;
        end

        if (cmd.walk_start)
        begin
            rd_idx_next     = '0;
            b_valid_next    = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (cmd.walk_adv)
        begin
            // Issue the read of the next entry while the previous is examined.
            if (walk_more)
            begin
                mem_re       = 1'b1;
                mem_raddr    = slot_of(front_reg, rd_idx_reg);
                rd_idx_next  = rd_idx_reg + 1'b1;
                b_idx_next   = rd_idx_reg;
                b_valid_next = 1'b1;
            end
            else
            begin
                b_valid_next = 1'b0;
            end

            if (b_valid_reg)
            begin
                if (op_reg == CMD_LIST)
                begin
                    emit             = 1'b1;
                    res_new.position = 5'(b_idx_reg + CW'(1));
                    res_new.element  = rd_data_reg;
                    res_new.last     = b_last;
                end
                else if (b_match)
                begin
                    // A held match goes out once a later one is known.
                    if (pend_valid_reg)
                    begin
                        emit             = 1'b1;
                        res_new.position = pend_pos_reg;
                        res_new.element  = key_reg;
                        res_new.last     = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_pos_next   = 5'(b_idx_reg + CW'(1));
                end
            end
        end

        if (cmd.walk_final)
        begin
            emit = 1'b1;
            if (pend_valid_reg)
            begin
                res_new.position = pend_pos_reg;
                res_new.element  = key_reg;
            end
            else
            begin
                res_new.status = ST_NOTFOUND;
            end
        end
    end

    // Ring store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= key_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            occ_reg        <= '0;
            b_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            occ_reg        <= occ_next;
            b_valid_reg    <= b_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= item.command;
            key_reg <= item.value;
        end
        rd_idx_reg   <= rd_idx_next;
        b_idx_reg    <= b_idx_next;
        pend_pos_reg <= pend_pos_next;
        if (emit)
        begin
            out_reg <= res_new;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> sv/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
//   channel  | beat     | handshake                  | direction
//   ---------+----------+----------------------------+----------
//   item     | item_t   | item_valid / item_stall    | in
//   result   | result_t | result_valid / result_stall| out
//
// One command is worked at a time. Push, count and bare status answers are
// written straight into the result register; a pop first reads its entry
// through the store's registered read port. Search and list walk the stored
// entries through that port one per cycle while no held result beat stalls the
// walk. Reset empties the list at once; stored entries need no clearing.
// A stalled result beat holds in the result register and the walk waits on it.
module bounded_deque_with_search_top
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     emitting;

    bdq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (dp_stat),
        .cmd        (dp_cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Commands that write a new beat into the result register.
    assign emitting = dp_cmd.push || dp_cmd.emit_status || dp_cmd.emit_count ||
                      dp_cmd.pop_emit || dp_cmd.walk_final ||
                      (dp_cmd.walk_adv && dp_stat.b_emit);

    // A new result beat never overwrites one that is still held.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emitting |-> dp_stat.out_free)
        else $error("result beat written while the result register is held");

    // A push is never carried out on a full list.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.push |-> !dp_stat.full)
        else $error("push carried out on a full list");

    // A pop is never carried out on an empty list.
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.pop_issue |-> !dp_stat.empty)
        else $error("pop carried out on an empty list");

    // Once a beat is accepted the block is busy on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second beat accepted without working the first");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for bounded_deque_with_search_top.
// Depends on bdq_pkg and the top level; drives commands, predicts every
// result beat from its own deque model and checks them in order.
`timescale 1ns / 100ps

module tb_top;
    import bdq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CMDS = 82;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mode_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Commands waiting to be driven and result beats waiting to arrive.
    item_t   queued_cmds[$];
    result_t pending_results[$];

    // Predictor state: ring store, index of the front element and fill level.
    logic signed [31:0] ring[DEPTH];
    logic [3:0]         head;
    logic [4:0]         fill;

    // Generator bookkeeping used only to shape the random stimulus.
    int                 occ_guess;
    logic signed [31:0] recent_vals[$];

    int   fails = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    logic item_taken = 1'b0;

    bounded_deque_with_search_top #(.DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // No idling near the end of the run and over one stretch in the middle.
    function automatic bit quiet_now();
        return queued_cmds.size() < 20 ||
               (queued_cmds.size() >= 50 && queued_cmds.size() < 65);
    endfunction

    // Works out the result beats of one accepted command and updates the model.
    task automatic apply_command(input item_t cmd);
        result_t r;
        int      last_hit;
        logic [3:0] slot;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        last_hit = -1;
        case (cmd.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (fill == DEPTH)
                    r.status = ST_FULL;
                else if (cmd.command == CMD_PUSH_FRONT)
                begin
                    head = head - 4'd1;
                    ring[head] = cmd.value;
                    fill = fill + 5'd1;
                end
                else
                begin
                    ring[head + fill[3:0]] = cmd.value;
                    fill = fill + 5'd1;
                end
                pending_results.push_back(r);
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else if (cmd.command == CMD_POP_FRONT)
                begin
                    r.element = ring[head];
                    head = head + 4'd1;
                    fill = fill - 5'd1;
                end
                else
                begin
                    r.element = ring[head + 4'(fill - 5'd1)];
                    fill = fill - 5'd1;
                end
                pending_results.push_back(r);
            end
            CMD_COUNT:
            begin
                r.position = fill;
                pending_results.push_back(r);
            end
            CMD_SEARCH:
            begin
                if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < fill; i++)
                        if (ring[head + 4'(i)] == cmd.value)
                            last_hit = i;
                    if (last_hit < 0)
                    begin
                        r.status = ST_NOTFOUND;
                        pending_results.push_back(r);
                    end
                    for (int i = 0; i <= last_hit; i++)
                    begin
                        slot = head + 4'(i);
                        if (ring[slot] == cmd.value)
                        begin
                            r.position = 5'(i + 1);
                            r.element = cmd.value;
                            r.last = (i == last_hit);
                            pending_results.push_back(r);
                        end
                    end
                end
            end
            CMD_LIST:
            begin
                if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end
                for (int i = 0; i < fill; i++)
                begin
                    r.position = 5'(i + 1);
                    r.element = ring[head + 4'(i)];
                    r.last = (i == fill - 1);
                    pending_results.push_back(r);
                end
            end
            default:
            begin
                // The unused code is dropped without a result.
            end
        endcase
    endtask

    // Queues one command and keeps the generator's rough view of the list.
    task automatic add_cmd(input logic [2:0] code, input logic signed [31:0] val);
        item_t c;
        c.command = code;
        c.value = val;
        queued_cmds.push_back(c);
        if (code == CMD_PUSH_FRONT || code == CMD_PUSH_BACK)
        begin
            if (occ_guess < DEPTH)
                occ_guess++;
            recent_vals.push_back(val);
            if (recent_vals.size() > 8)
                void'(recent_vals.pop_front());
        end
        else if ((code == CMD_POP_FRONT || code == CMD_POP_BACK) && occ_guess > 0)
            occ_guess--;
    endtask

    // Push values: often a few repeated ones so that searches hit several times.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sd5;
            1: return -32'sd5;
            2: return 32'sh8000_0000;
            3: return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (recent_vals.size() > 0 && $urandom_range(0, 9) < 7)
            return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        return pick_value();
    endfunction

    // Chooses one command with a bias that depends on the current phase.
    function automatic logic [2:0] pick_cmd(input mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                r = (r < 75) ? 0 : (r < 85) ? 2 : (r < 90) ? 3 : (r < 95) ? 4 : 1;
            MODE_DRAIN:
                r = (r < 70) ? 1 : (r < 80) ? 2 : (r < 88) ? 3 : (r < 94) ? 4 : 0;
            default:
                r = (r < 30) ? 0 : (r < 55) ? 1 : (r < 75) ? 2 : (r < 87) ? 3 : 4;
        endcase
        case (r)
            0: return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            1: return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            2: return CMD_SEARCH;
            3: return CMD_LIST;
            default: return CMD_COUNT;
        endcase
    endfunction

    // Driver: a new beat or an idle cycle once the current beat has gone.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_gap = 0;
        end
        else if (!item_valid || item_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (queued_cmds.size() == 0)
                item_valid <= 1'b0;
            else if (!quiet_now() && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 12);
                item_valid <= 1'b0;
            end
            else
            begin
                item <= queued_cmds.pop_front();
                item_valid <= 1'b1;
            end
        end
    end

    // Receiver back-pressure in random bursts.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!quiet_now() && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 12);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Monitor: predict on each accepted command, check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
                apply_command(item);
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", result);
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        fails++;
                    end
                    if (result.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, result.position);
                        fails++;
                    end
                    if (result.element !== want.element)
                    begin
                        $error("element: expected %0d, got %0d",
                               want.element, result.element);
                        fails++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, result.last);
                        fails++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        mode_t mode;
        int    made;
        int    run;
        logic [2:0] code;

        head = '0;
        fill = '0;
        occ_guess = 0;
        made = 0;

        // Directed part: everything on an empty list first.
        add_cmd(CMD_LIST, 0);
        add_cmd(CMD_SEARCH, 32'sd7);
        add_cmd(CMD_POP_FRONT, 0);
        add_cmd(CMD_POP_BACK, 0);
        add_cmd(CMD_COUNT, -32'sd1);
        // Extreme values at both ends, then counting, listing and searching.
        add_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
        add_cmd(CMD_PUSH_BACK, 32'sh7fff_ffff);
        add_cmd(CMD_PUSH_FRONT, -32'sd1);
        add_cmd(CMD_PUSH_BACK, 32'sd0);
        add_cmd(CMD_COUNT, 0);
        add_cmd(CMD_LIST, 0);
        add_cmd(CMD_SEARCH, -32'sd1);
        add_cmd(CMD_SEARCH, 32'sh7fff_ffff);
        add_cmd(CMD_SEARCH, 32'sd12345);
        add_cmd(CMD_PUSH_BACK, -32'sd1);
        add_cmd(CMD_SEARCH, -32'sd1);
        add_cmd(CMD_UNUSED, 32'sh5a5a_a5a5);
        // Drain through a one-element list and push onto the emptied list.
        add_cmd(CMD_POP_FRONT, 0);
        add_cmd(CMD_POP_BACK, 0);
        add_cmd(CMD_POP_FRONT, 0);
        add_cmd(CMD_POP_BACK, 0);
        add_cmd(CMD_POP_FRONT, 0);
        add_cmd(CMD_COUNT, 0);
        add_cmd(CMD_PUSH_FRONT, 32'sd5);
        add_cmd(CMD_LIST, 0);

        // Random part: phases that fill, drain or mix, with random content.
        mode = MODE_FILL;
        while (made < RANDOM_CMDS)
        begin
            run = $urandom_range(10, 24);
            for (int k = 0; k < run && made < RANDOM_CMDS; k++)
            begin
                if ($urandom_range(0, 32) == 0)
                    add_cmd(CMD_UNUSED, $urandom);
                code = pick_cmd(mode);
                if (code == CMD_SEARCH)
                    add_cmd(code, pick_key());
                else if (code == CMD_PUSH_FRONT || code == CMD_PUSH_BACK)
                    add_cmd(code, pick_value());
                else
                    add_cmd(code, $urandom);
                made++;
            end
            // Head for the other end once the list is near full or empty.
            if (occ_guess >= DEPTH - 2)
                mode = ($urandom_range(0, 3) == 0) ? MODE_MIX : MODE_DRAIN;
            else if (occ_guess <= 2)
                mode = MODE_FILL;
            else
                mode = mode_t'($urandom_range(0, 2));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (queued_cmds.size() == 0 && !item_valid);
        wait (pending_results.size() == 0);
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
